### hdl/rspa_pkg.sv
// shared types and constants for the refcounted slot pool allocator
package rspa_pkg;

    localparam int SLOTS          = 8;
    localparam int SLOT_BITS      = 3;
    localparam int FILL_BITS      = 4;
    localparam int MAP_BITS       = 8;
    localparam int COUNT_BITS_DEF = 8;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_COLLECT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EXHAUSTED = 3'd1,
        STAT_NOT_LIVE  = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_SATURATED = 3'd4
    } t_status;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [SLOT_BITS-1:0] push_slot;
    } t_queue_ctl;

    typedef struct packed {
        t_status              status;
        logic [SLOT_BITS-1:0] result_slot;
        logic                 reached_zero;
        logic [FILL_BITS-1:0] live_count;
        logic [MAP_BITS-1:0]  used_map;
        logic [FILL_BITS-1:0] pending_count;
    } t_result;

endpackage

### hdl/rspa_queue.sv
// collection fifo of slots whose count dropped to zero
module rspa_queue
    import rspa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_queue_ctl           i_ctl,
    output logic [SLOT_BITS-1:0] o_head_slot,
    output logic [FILL_BITS-1:0] o_fill,
    output logic [FILL_BITS-1:0] o_next_fill,
    output logic                 o_full
);

    logic [SLOT_BITS-1:0] r_entry [SLOTS];
    logic [SLOT_BITS-1:0] r_head;
    logic [SLOT_BITS-1:0] r_tail;
    logic [FILL_BITS-1:0] r_fill;
    logic [SLOT_BITS-1:0] n_head;
    logic [SLOT_BITS-1:0] n_tail;
    logic [FILL_BITS-1:0] n_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.pop) begin
            n_head = r_head + SLOT_BITS'(1);
        end
        if (i_ctl.push) begin
            n_tail = r_tail + SLOT_BITS'(1);
        end
        n_fill = r_fill + FILL_BITS'(i_ctl.push) - FILL_BITS'(i_ctl.pop);
    end

    assign o_head_slot = r_entry[r_head];
    assign o_fill      = r_fill;
    assign o_next_fill = n_fill;
    assign o_full      = (r_fill == FILL_BITS'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry[r_tail] <= i_ctl.push_slot;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(SLOTS))
        else $error("queue fill above depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == SLOT_BITS'(r_head + r_fill[SLOT_BITS-1:0]))
        else $error("queue pointers disagree with fill");
`endif

endmodule

### hdl/rspa_core.sv
// slot marks, reference counts and the per-item update logic
module rspa_core
    import rspa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  t_mode                i_mode,
    input  logic [SLOT_BITS-1:0] i_slot,
    output t_result              o_res
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [SLOTS-1:0]      r_used;
    logic [SLOTS-1:0]      n_used;
    logic [COUNT_BITS-1:0] r_count [SLOTS];
    logic [COUNT_BITS-1:0] n_count [SLOTS];
    logic [COUNT_BITS-1:0] w_sel_count;
    logic                  w_free_found;
    logic [SLOT_BITS-1:0]  w_free_slot;
    logic [SLOTS-1:0]      w_live_mask;
    t_queue_ctl            w_qctl;
    logic [SLOT_BITS-1:0]  w_head_slot;
    logic [FILL_BITS-1:0]  w_fill;
    logic [FILL_BITS-1:0]  w_next_fill;
    logic                  w_q_full;
    t_result               w_res;

    rspa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_qctl),
        .o_head_slot (w_head_slot),
        .o_fill      (w_fill),
        .o_next_fill (w_next_fill),
        .o_full      (w_q_full)
    );

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_live_mask[i] = (r_count[i] != '0);
        end
    end

    assign w_sel_count = r_count[i_slot];

    always_comb begin
        n_used = r_used;
        n_count = r_count;
        w_qctl = '0;
        w_res = '0;
        w_res.status = STAT_OK;
        case (i_mode)
            MODE_ALLOC: begin
                if (w_free_found) begin
                    n_used[w_free_slot]  = 1'b1;
                    n_count[w_free_slot] = COUNT_BITS'(1);
                    w_res.result_slot    = w_free_slot;
                end else begin
                    w_res.status = STAT_EXHAUSTED;
                end
            end
            MODE_ADD: begin
                if (w_sel_count == '0) begin
                    w_res.status = STAT_NOT_LIVE;
                end else if (w_sel_count == COUNT_MAX) begin
                    w_res.status = STAT_SATURATED;
                end else begin
                    n_count[i_slot] = w_sel_count + COUNT_BITS'(1);
                end
            end
            MODE_RELEASE: begin
                if (w_sel_count == '0) begin
                    w_res.status = STAT_NOT_LIVE;
                end else begin
                    n_count[i_slot] = w_sel_count - COUNT_BITS'(1);
                    if (w_sel_count == COUNT_BITS'(1)) begin
                        w_res.reached_zero = 1'b1;
                        w_qctl.push        = i_fire && !w_q_full;
                        w_qctl.push_slot   = i_slot;
                    end
                end
            end
            MODE_COLLECT: begin
                if (w_fill == '0) begin
                    w_res.status = STAT_EMPTY;
                end else begin
                    w_qctl.pop          = i_fire;
                    n_used[w_head_slot] = 1'b0;
                    w_res.result_slot   = w_head_slot;
                end
            end
            default: begin
                w_res.status = STAT_OK;
            end
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            w_res.live_count = w_res.live_count + FILL_BITS'(n_used[i]);
        end
        w_res.used_map      = n_used;
        w_res.pending_count = i_fire ? w_next_fill : w_fill;
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_fire) begin
            r_used <= n_used;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_live_is_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_live_mask & ~r_used) == '0)
        else $error("slot with references not marked used");

    a_dead_used_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used & ~w_live_mask) == int'(w_fill))
        else $error("queued slots disagree with dead used slots");
`endif

endmodule

### hdl/refcounted_slot_pool_allocator.sv
// top level of the refcounted slot pool allocator: input and result registers
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_mode, i_slot
//  out      from block o_out_valid / i_out_stall o_status, o_result_slot, o_reached_zero,
//                                                o_live_count, o_used_map, o_pending_count
//
//  one item per cycle while neither side stalls; an accepted item passes the input register
//  and then the result register before its result shows
//  the pool state updates as the item moves from the input register to the result register
//  synchronous active-low reset empties the pool and the collection queue
//  a stalled result holds the input register, which then stalls the input side
module refcounted_slot_pool_allocator
    import rspa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [SLOT_BITS-1:0] i_slot,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [SLOT_BITS-1:0] o_result_slot,
    output logic                 o_reached_zero,
    output logic [FILL_BITS-1:0] o_live_count,
    output logic [MAP_BITS-1:0]  o_used_map,
    output logic [FILL_BITS-1:0] o_pending_count
);

    logic                 r_in_valid;
    t_mode                r_in_mode;
    logic [SLOT_BITS-1:0] r_in_slot;
    logic                 r_out_valid;
    t_result              r_res;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_in_free;
    t_result              w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_fire;
    assign o_in_stall = !w_in_free;

    rspa_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_mode  (r_in_mode),
        .i_slot  (r_in_slot),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_free) begin
            r_in_mode <= t_mode'(i_mode);
            r_in_slot <= i_slot;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res.status;
    assign o_result_slot   = r_res.result_slot;
    assign o_reached_zero  = r_res.reached_zero;
    assign o_live_count    = r_res.live_count;
    assign o_used_map      = r_res.used_map;
    assign o_pending_count = r_res.pending_count;

`ifndef SYNTHESIS
    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed item did not reach the result register");
`endif

endmodule
